>>> rtl/plc_pkg.sv
// Shared types, constants and helpers for the piecewise-linear calibrator.
// No dependencies.
package plc_pkg;

    localparam int VAL_W  = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 36;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_CORRECT = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_FLAG,
        S_WRITE,
        S_SEL,
        S_DIFF,
        S_MUL,
        S_DGO,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic flag;
        logic ins;
        logic rep;
    } t_cell_cmd;

    typedef struct packed {
        logic hit;
        logic ge;
        logic gt;
    } t_cell_flags;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7fff_ffff);
        lo = -SUM_W'(32'sh7fff_ffff) - SUM_W'(1);
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

>>> rtl/piecewise_linear_calibrator.sv
// Piecewise-linear calibrator: per-channel sorted point tables in a row of cells.
// Depends on plc_pkg, plc_cell and plc_div.
//
// One item at a time. An add passes the read, flag and write states; clear and
// unused items, refused adds and a correct item with zero or one point skip the
// write; an interpolating correct item also passes select, difference, multiply
// and divide. The divide uses the 64 / 32 divider that retires two quotient bits
// per cycle in 32 steps. Table search and insertion are done by all MAX_POINTS
// cells at once, each shifting from its left neighbor. No clearing pass: clearing
// a channel zeroes its point count. The next item can be taken in the cycle after
// the result is loaded, while that result may still wait on the output.
module piecewise_linear_calibrator #(
    parameter int MAX_POINTS = 16,
    parameter int CHANNELS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [2:0]          i_channel,
    input  logic signed [31:0]  i_raw_value,
    input  logic signed [31:0]  i_reference_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_status,
    output logic signed [31:0]  o_corrected_value,
    output logic [4:0]          o_point_count
);
    import plc_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state              r_state;
    t_state              n_state;
    t_kind               r_kind;
    logic [2:0]          r_chan;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_count [CHANNELS];
    logic                r_status;
    logic signed [31:0]  r_res;
    logic signed [31:0]  r_x1;
    logic signed [31:0]  r_x2;
    logic signed [31:0]  r_y1;
    logic signed [31:0]  r_y2;
    logic [31:0]         r_ma;
    logic [31:0]         r_mb;
    logic [31:0]         r_md;
    logic                r_neg;
    logic                r_dzero;
    logic [PROD_W-1:0]   r_prod;
    logic                r_oval;
    logic                r_ostatus;
    logic signed [31:0]  r_ocorr;
    logic [4:0]          r_ocnt;

    t_cell_cmd           cmd;
    logic                accept;
    logic                out_load;
    logic                div_start;
    logic                div_done;
    logic [PROD_W-1:0]   quo;
    logic                chan_ok;
    logic [CH_W-1:0]     ch_idx;
    logic                full;

    logic signed [31:0]  c_raw [MAX_POINTS];
    logic signed [31:0]  c_ref [MAX_POINTS];
    logic                c_at  [MAX_POINTS];
    t_cell_flags         c_flg [MAX_POINTS];
    logic [MAX_POINTS-1:0] gt_v;
    logic [MAX_POINTS-1:0] hit_v;
    logic [MAX_POINTS-1:0] lo_v;

    logic signed [31:0]  s_x1;
    logic signed [31:0]  s_x2;
    logic signed [31:0]  s_y1;
    logic signed [31:0]  s_y2;
    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [32:0]  dd;
    logic signed [SUM_W-1:0] one_sum;
    logic [33:0]         qc;
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] fin_sum;

    assign chan_ok = int'(r_chan) < CHANNELS;
    assign ch_idx  = CH_W'(r_chan);
    assign full    = int'(r_n) >= MAX_POINTS;
    assign accept  = i_valid && !o_stall;

    // cell row
    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
        logic signed [31:0] left_raw;
        logic signed [31:0] left_ref;
        logic               left_at;
        if (j == 0) begin : g_first
            assign left_raw = '0;
            assign left_ref = '0;
            assign left_at  = 1'b0;
        end else begin : g_rest
            assign left_raw = c_raw[j-1];
            assign left_ref = c_ref[j-1];
            assign left_at  = c_at[j-1];
        end
        plc_cell #(
            .IDX      (j),
            .CHANNELS (CHANNELS),
            .CH_W     (CH_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_ch       (ch_idx),
            .i_n        (r_n),
            .i_x        (r_x),
            .i_y        (r_y),
            .i_left_raw (left_raw),
            .i_left_ref (left_ref),
            .i_left_at  (left_at),
            .o_at       (c_at[j]),
            .o_raw      (c_raw[j]),
            .o_ref      (c_ref[j]),
            .o_flags    (c_flg[j])
        );
        assign gt_v[j]  = c_flg[j].gt;
        assign hit_v[j] = c_flg[j].hit;
    end

    // interval pick: first point above the sample, clamped to the end pairs
    always_comb begin
        lo_v = '0;
        s_x1 = '0;
        s_x2 = '0;
        s_y1 = '0;
        s_y2 = '0;
        for (int j = 0; j < MAX_POINTS - 1; j++) begin
            lo_v[j] = (j == 0 && gt_v[0]) || (!(|gt_v) && int'(r_n) - 2 == j)
                      || (gt_v[j+1] && !gt_v[j]);
            if (lo_v[j]) begin
                s_x1 = s_x1 | c_raw[j];
                s_y1 = s_y1 | c_ref[j];
                s_x2 = s_x2 | c_raw[j+1];
                s_y2 = s_y2 | c_ref[j+1];
            end
        end
    end

    always_comb begin
        dx      = 33'(r_x) - 33'(r_x1);
        dy      = 33'(r_y2) - 33'(r_y1);
        dd      = 33'(r_x2) - 33'(r_x1);
        one_sum = SUM_W'(c_ref[0]) - SUM_W'(c_raw[0]) + SUM_W'(r_x);
        qc      = (|quo[PROD_W-1:33]) ? 34'h2_0000_0000 : quo[33:0];
        qs      = r_neg ? -SUM_W'(qc) : SUM_W'(qc);
        fin_sum = qs + SUM_W'(r_y1);
    end

    plc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_md),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_FLAG;
            S_FLAG: begin
                if (!chan_ok) begin
                    n_state = S_DONE;
                end else if (r_kind == KIND_ADD) begin
                    n_state = full ? S_DONE : S_WRITE;
                end else if (r_kind == KIND_CORRECT && int'(r_n) >= 2) begin
                    n_state = S_SEL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_SEL:   n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_DGO;
            S_DGO:   n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_FIN;
            S_FIN:   n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall   = r_state != S_IDLE;
        cmd.load  = r_state == S_READ;
        cmd.flag  = r_state == S_FLAG;
        cmd.ins   = r_state == S_WRITE && !(|hit_v);
        cmd.rep   = r_state == S_WRITE && (|hit_v);
        div_start = r_state == S_DGO;
        out_load  = r_state == S_DONE && (!r_oval || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            if (r_state == S_FLAG && chan_ok && r_kind == KIND_CLEAR) begin
                r_count[ch_idx] <= '0;
            end
            if (cmd.ins) begin
                r_count[ch_idx] <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= t_kind'(i_kind);
            r_chan   <= i_channel;
            r_x      <= i_raw_value;
            r_y      <= i_reference_value;
            r_status <= 1'b0;
            r_res    <= '0;
        end
        if (r_state == S_READ) begin
            r_n <= chan_ok ? r_count[ch_idx] : '0;
        end
        if (r_state == S_FLAG && chan_ok) begin
            case (r_kind)
                KIND_ADD:   r_status <= full;
                KIND_CLEAR: r_n <= '0;
                KIND_CORRECT: begin
                    if (r_n == '0) begin
                        r_res <= r_x;
                    end else if (int'(r_n) == 1) begin
                        r_res <= sat32(one_sum);
                    end
                end
                default: ;
            endcase
        end
        if (cmd.ins) begin
            r_n <= r_n + 1'b1;
        end
        if (r_state == S_SEL) begin
            r_x1 <= s_x1;
            r_x2 <= s_x2;
            r_y1 <= s_y1;
            r_y2 <= s_y2;
        end
        if (r_state == S_DIFF) begin
            r_ma    <= dx[32] ? 32'(-dx) : dx[31:0];
            r_mb    <= dy[32] ? 32'(-dy) : dy[31:0];
            r_md    <= dd[32] ? 32'(-dd) : dd[31:0];
            r_neg   <= dx[32] ^ dy[32] ^ dd[32];
            r_dzero <= dd == '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_ma) * PROD_W'(r_mb);
        end
        if (r_state == S_FIN) begin
            r_res <= r_dzero ? r_y1 : sat32(fin_sum);
        end
        if (out_load) begin
            r_ostatus <= r_status;
            r_ocorr   <= r_res;
            r_ocnt    <= 5'(r_n);
        end
    end

    assign o_valid           = r_oval;
    assign o_status          = r_ostatus;
    assign o_corrected_value = r_ocorr;
    assign o_point_count     = r_ocnt;

    // count register is only meaningful once it has been loaded for an item
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE && r_state != S_READ |-> int'(r_n) <= MAX_POINTS)
        else $error("point count above table size");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_status |-> r_kind == KIND_ADD && full)
        else $error("full status on an item that was not refused");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |=> r_state == S_DONE && $past(chan_ok))
        else $error("table write not followed by result");

endmodule

>>> rtl/plc_cell.sv
// One table slot: holds point IDX of every channel, compares against the item,
// and shifts from its left neighbor on an insert. Depends on plc_pkg.
module plc_cell #(
    parameter int IDX      = 0,
    parameter int CHANNELS = 8,
    parameter int CH_W     = 3,
    parameter int CNT_W    = 5
) (
    input  logic                       i_clk,
    input  plc_pkg::t_cell_cmd         i_cmd,
    input  logic [CH_W-1:0]            i_ch,
    input  logic [CNT_W-1:0]           i_n,
    input  logic signed [31:0]         i_x,
    input  logic signed [31:0]         i_y,
    input  logic signed [31:0]         i_left_raw,
    input  logic signed [31:0]         i_left_ref,
    input  logic                       i_left_at,
    output logic                       o_at,
    output logic signed [31:0]         o_raw,
    output logic signed [31:0]         o_ref,
    output plc_pkg::t_cell_flags       o_flags
);
    import plc_pkg::*;

    logic signed [31:0] r_raw [CHANNELS];
    logic signed [31:0] r_ref [CHANNELS];
    logic signed [31:0] r_rd_raw;
    logic signed [31:0] r_rd_ref;
    t_cell_flags        r_flags;
    logic               live;
    logic               reach;

    assign live  = int'(i_n) > IDX;
    assign reach = int'(i_n) >= IDX;
    // at or past the insert position; slots beyond the count always are
    assign o_at    = live ? r_flags.ge : 1'b1;
    assign o_raw   = r_rd_raw;
    assign o_ref   = r_rd_ref;
    assign o_flags = r_flags;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_raw <= r_raw[i_ch];
            r_rd_ref <= r_ref[i_ch];
        end
        if (i_cmd.flag) begin
            r_flags.hit <= live && (r_rd_raw == i_x);
            r_flags.ge  <= r_rd_raw >= i_x;
            r_flags.gt  <= live && (r_rd_raw > i_x);
        end
        if (i_cmd.ins && reach) begin
            if (o_at && !i_left_at) begin
                r_raw[i_ch] <= i_x;
                r_ref[i_ch] <= i_y;
            end else if (i_left_at) begin
                r_raw[i_ch] <= i_left_raw;
                r_ref[i_ch] <= i_left_ref;
            end
        end
        if (i_cmd.rep && live && r_flags.hit) begin
            r_ref[i_ch] <= i_y;
        end
    end

endmodule

>>> rtl/plc_div.sv
// Unsigned 64 / 32 restoring divider, two quotient bits per cycle.
// Depends on plc_pkg.
module plc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plc_pkg::PROD_W-1:0]    i_dividend,
    input  logic [31:0]                   i_divisor,
    output logic                          o_done,
    output logic [plc_pkg::PROD_W-1:0]    o_quotient
);
    import plc_pkg::*;

    localparam int STEPS = PROD_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic [PROD_W-1:0] r_dvd;
    logic [PROD_W-1:0] r_quo;
    logic [31:0]       r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_run;
    logic              r_done;
    logic [32:0]       t1;
    logic [32:0]       t2;
    logic [31:0]       rem1;
    logic [31:0]       rem2;
    logic              ge1;
    logic              ge2;

    always_comb begin
        t1   = {r_rem, r_dvd[PROD_W-1]};
        ge1  = t1 >= {1'b0, i_divisor};
        rem1 = ge1 ? 32'(t1 - {1'b0, i_divisor}) : t1[31:0];
        t2   = {rem1, r_dvd[PROD_W-2]};
        ge2  = t2 >= {1'b0, i_divisor};
        rem2 = ge2 ? 32'(t2 - {1'b0, i_divisor}) : t2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[PROD_W-3:0], 2'b00};
            r_quo <= {r_quo[PROD_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
